// File: design/tac_pkg.sv
// Shared types, constants and the solver micro-program for the touch calibration core.
// No dependencies; every other file refers to this package by scoped names.
package tac_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int COORD_BITS    = 16;
    localparam int XY_W          = 16;
    localparam int ACC_W         = 52;
    localparam int DEN_W         = 36;
    localparam int OPA_W         = 34;
    localparam int OPB_W         = 17;
    localparam int PRD_W         = OPA_W + OPB_W;
    localparam int PQR_W         = 33;
    localparam int COEF_W        = 32;
    localparam int PC_W          = 5;
    localparam int CIDX_W        = 3;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_XFORM = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        A_T0X, A_T0Y, A_T1X, A_T1Y, A_S0, A_S1, A_S2, A_S12, A_P, A_Q, A_R, A_COEF
    } a_sel_t;

    typedef enum logic [3:0] {
        B_T0X, B_T0Y, B_T1X, B_T1Y, B_T2X, B_T2Y, B_D21Y, B_D12X, B_S0, B_TX, B_TY, B_ONE
    } b_sel_t;

    typedef enum logic [2:0] {
        SV_NONE, SV_DET, SV_P, SV_Q, SV_R, SV_DIV, SV_OUTX, SV_OUTY
    } save_t;

    typedef enum logic [1:0] {
        OUT_ZERO, OUT_PASS, OUT_XFORM
    } out_sel_t;

    typedef struct packed {
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        logic                clr;
        logic                neg;
        save_t               save;
        logic                stop;
        logic [CIDX_W-1:0]   cidx;
    } uop_t;

    typedef struct packed {
        logic      issue;
        uop_t      uop;
        logic      k;
        logic      store;
        logic      ld_in;
        logic      out_load;
        out_sel_t  out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } dp_stat_t;

    localparam logic [PC_W-1:0]   PC_SOLVE = 5'd0;
    localparam logic [PC_W-1:0]   PC_LOOP  = 5'd6;
    localparam logic [PC_W-1:0]   PC_XFORM = 5'd21;
    localparam logic [CIDX_W-1:0] CIDX_N2  = 3'd2;

    // Multiply-accumulate program: determinant, shared cofactor P, then per axis
    // Q, R and the three numerators; the transform runs from PC_XFORM.
    function automatic uop_t tac_uop(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = '{A_T0X,  B_D21Y, 1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd1:  u = '{A_T1X,  B_T2Y,  1'b0, 1'b1, SV_NONE, 1'b0, 3'd0};
            5'd2:  u = '{A_T1Y,  B_T2X,  1'b0, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd3:  u = '{A_T0Y,  B_D12X, 1'b0, 1'b0, SV_DET,  1'b1, 3'd0};
            5'd4:  u = '{A_T1Y,  B_T2X,  1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd5:  u = '{A_T1X,  B_T2Y,  1'b0, 1'b1, SV_P,    1'b0, 3'd0};
            5'd6:  u = '{A_S1,   B_T2Y,  1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd7:  u = '{A_S2,   B_T1Y,  1'b0, 1'b1, SV_Q,    1'b0, 3'd0};
            5'd8:  u = '{A_S2,   B_T1X,  1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd9:  u = '{A_S1,   B_T2X,  1'b0, 1'b1, SV_R,    1'b0, 3'd0};
            5'd10: u = '{A_S0,   B_D21Y, 1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd11: u = '{A_S1,   B_T2Y,  1'b0, 1'b1, SV_NONE, 1'b0, 3'd0};
            5'd12: u = '{A_S2,   B_T1Y,  1'b0, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd13: u = '{A_S12,  B_T0Y,  1'b0, 1'b0, SV_DIV,  1'b1, 3'd0};
            5'd14: u = '{A_S0,   B_D12X, 1'b1, 1'b0, SV_NONE, 1'b0, 3'd1};
            5'd15: u = '{A_S1,   B_T2X,  1'b0, 1'b0, SV_NONE, 1'b0, 3'd1};
            5'd16: u = '{A_S2,   B_T1X,  1'b0, 1'b1, SV_NONE, 1'b0, 3'd1};
            5'd17: u = '{A_S12,  B_T0X,  1'b0, 1'b1, SV_DIV,  1'b1, 3'd1};
            5'd18: u = '{A_P,    B_S0,   1'b1, 1'b0, SV_NONE, 1'b0, 3'd2};
            5'd19: u = '{A_Q,    B_T0X,  1'b0, 1'b0, SV_NONE, 1'b0, 3'd2};
            5'd20: u = '{A_R,    B_T0Y,  1'b0, 1'b0, SV_DIV,  1'b1, 3'd2};
            5'd21: u = '{A_COEF, B_TX,   1'b1, 1'b0, SV_NONE, 1'b0, 3'd0};
            5'd22: u = '{A_COEF, B_TY,   1'b0, 1'b0, SV_NONE, 1'b0, 3'd1};
            5'd23: u = '{A_COEF, B_ONE,  1'b0, 1'b0, SV_OUTX, 1'b0, 3'd2};
            5'd24: u = '{A_COEF, B_TX,   1'b1, 1'b0, SV_NONE, 1'b0, 3'd3};
            5'd25: u = '{A_COEF, B_TY,   1'b0, 1'b0, SV_NONE, 1'b0, 3'd4};
            5'd26: u = '{A_COEF, B_ONE,  1'b0, 1'b0, SV_OUTY, 1'b1, 3'd5};
            default: u = '{A_T0X, B_T0X, 1'b1, 1'b0, SV_NONE, 1'b1, 3'd0};
        endcase
        return u;
    endfunction

endpackage

// File: design/tac_div.sv
// Sequential signed divider: (num << FRAC_BITS) / den, truncated, saturated to 32 bits.
// Restoring, one quotient bit per cycle. Depends on tac_pkg.
module tac_div #(
    parameter int FRAC_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [tac_pkg::ACC_W-1:0]    num,
    input  logic signed [tac_pkg::DEN_W-1:0]    den,
    output logic                                done,
    output logic        [tac_pkg::COEF_W-1:0]   quo
);

    localparam int DV_W  = tac_pkg::ACC_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DV_W);
    localparam int DN_W  = tac_pkg::DEN_W;

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DV_W-1:0]   dvd_reg, dvd_next;
    logic [DV_W-1:0]   q_reg, q_next;
    logic [DN_W-1:0]   rem_reg, rem_next;
    logic [DN_W-1:0]   dsr_reg, dsr_next;
    logic              neg_reg, neg_next;

    logic [tac_pkg::ACC_W-1:0] num_mag;
    logic [DN_W:0]             trial;
    logic                      ge;
    logic                      big;

    assign num_mag = num[tac_pkg::ACC_W-1] ? tac_pkg::ACC_W'(-num) : num;
    assign trial   = {rem_reg, dvd_reg[DV_W-1]};
    assign ge      = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = DV_W'(num_mag) << FRAC_BITS;
            q_next    = '0;
            rem_next  = '0;
            dsr_next  = den[DN_W-1] ? DN_W'(-den) : den;
            neg_next  = num[tac_pkg::ACC_W-1] ^ den[DN_W-1];
        end else if (busy_reg) begin
            rem_next = ge ? DN_W'(trial - {1'b0, dsr_reg}) : trial[DN_W-1:0];
            q_next   = {q_reg[DV_W-2:0], ge};
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DV_W - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // quotient of 2^31 or more saturates either way
    assign big  = |q_reg[DV_W-1:tac_pkg::COEF_W-1];
    assign done = fin_reg;

    always_comb begin
        if (neg_reg) begin
            quo = big ? 32'h8000_0000 : (32'd0 - q_reg[tac_pkg::COEF_W-1:0]);
        end else begin
            quo = big ? 32'h7FFF_FFFF : q_reg[tac_pkg::COEF_W-1:0];
        end
    end

endmodule

// File: design/tac_datapath.sv
// Datapath: calibration point store, shared multiply-accumulate unit, coefficient
// registers, divider and result payload. Depends on tac_pkg and tac_div.
module tac_datapath #(
    parameter int FRAC_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tac_pkg::dp_cmd_t                  cmd,
    output tac_pkg::dp_stat_t                 stat,
    input  logic        [1:0]                 in_pair_index,
    input  logic signed [tac_pkg::XY_W-1:0]   in_screen_x,
    input  logic signed [tac_pkg::XY_W-1:0]   in_screen_y,
    input  logic signed [tac_pkg::XY_W-1:0]   in_touch_x,
    input  logic signed [tac_pkg::XY_W-1:0]   in_touch_y,
    output logic signed [tac_pkg::XY_W-1:0]   out_x,
    output logic signed [tac_pkg::XY_W-1:0]   out_y
);

    localparam int XY_W  = tac_pkg::XY_W;
    localparam int ACC_W = tac_pkg::ACC_W;
    localparam int OPA_W = tac_pkg::OPA_W;
    localparam int OPB_W = tac_pkg::OPB_W;
    localparam int PRD_W = tac_pkg::PRD_W;
    localparam int PQR_W = tac_pkg::PQR_W;
    localparam int DEN_W = tac_pkg::DEN_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (tac_pkg::COORD_BITS - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [XY_W-1:0] sx_reg [3];
    logic signed [XY_W-1:0] sy_reg [3];
    logic signed [XY_W-1:0] tx_reg [3];
    logic signed [XY_W-1:0] ty_reg [3];
    logic signed [XY_W-1:0] ptx_reg, pty_reg;
    logic signed [tac_pkg::COEF_W-1:0] coef_reg [6];

    logic signed [PRD_W-1:0] prod_reg;
    logic                    act_reg;
    tac_pkg::uop_t           uop_d_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [DEN_W-1:0] det_reg;
    logic signed [PQR_W-1:0] p_reg, q_reg, r_reg;
    logic signed [XY_W-1:0]  resx_reg, resy_reg;
    logic signed [XY_W-1:0]  outx_reg, outy_reg;
    logic [tac_pkg::CIDX_W-1:0] dest_reg;

    logic signed [XY_W-1:0]  s0, s1, s2;
    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    logic signed [ACC_W-1:0] prod_x;
    logic                    div_start, div_done;
    logic [tac_pkg::COEF_W-1:0] div_quo;

    function automatic logic signed [XY_W-1:0] shift_sat(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > SAT_HI) sh = SAT_HI;
        if (sh < SAT_LO) sh = SAT_LO;
        return sh[XY_W-1:0];
    endfunction

    assign s0 = cmd.k ? sy_reg[0] : sx_reg[0];
    assign s1 = cmd.k ? sy_reg[1] : sx_reg[1];
    assign s2 = cmd.k ? sy_reg[2] : sx_reg[2];

    always_comb begin
        case (cmd.uop.a_sel)
            tac_pkg::A_T0X:  opa = OPA_W'(tx_reg[0]);
            tac_pkg::A_T0Y:  opa = OPA_W'(ty_reg[0]);
            tac_pkg::A_T1X:  opa = OPA_W'(tx_reg[1]);
            tac_pkg::A_T1Y:  opa = OPA_W'(ty_reg[1]);
            tac_pkg::A_S0:   opa = OPA_W'(s0);
            tac_pkg::A_S1:   opa = OPA_W'(s1);
            tac_pkg::A_S2:   opa = OPA_W'(s2);
            tac_pkg::A_S12:  opa = OPA_W'(s1) - OPA_W'(s2);
            tac_pkg::A_P:    opa = OPA_W'(p_reg);
            tac_pkg::A_Q:    opa = OPA_W'(q_reg);
            tac_pkg::A_R:    opa = OPA_W'(r_reg);
            tac_pkg::A_COEF: opa = (cmd.uop.cidx < 3'd6) ? OPA_W'(coef_reg[cmd.uop.cidx])
                                                          : '0;
            default:         opa = '0;
        endcase
        case (cmd.uop.b_sel)
            tac_pkg::B_T0X:  opb = OPB_W'(tx_reg[0]);
            tac_pkg::B_T0Y:  opb = OPB_W'(ty_reg[0]);
            tac_pkg::B_T1X:  opb = OPB_W'(tx_reg[1]);
            tac_pkg::B_T1Y:  opb = OPB_W'(ty_reg[1]);
            tac_pkg::B_T2X:  opb = OPB_W'(tx_reg[2]);
            tac_pkg::B_T2Y:  opb = OPB_W'(ty_reg[2]);
            tac_pkg::B_D21Y: opb = OPB_W'(ty_reg[2]) - OPB_W'(ty_reg[1]);
            tac_pkg::B_D12X: opb = OPB_W'(tx_reg[1]) - OPB_W'(tx_reg[2]);
            tac_pkg::B_S0:   opb = OPB_W'(s0);
            tac_pkg::B_TX:   opb = OPB_W'(ptx_reg);
            tac_pkg::B_TY:   opb = OPB_W'(pty_reg);
            tac_pkg::B_ONE:  opb = OPB_W'(1);
            default:         opb = '0;
        endcase
    end

    // accumulate stage runs in the cycle after the multiply
    assign prod_x    = {{(ACC_W - PRD_W){prod_reg[PRD_W-1]}}, prod_reg};
    assign acc_next  = (uop_d_reg.clr ? ACC_W'(0) : acc_reg)
                     + (uop_d_reg.neg ? -prod_x : prod_x);
    assign div_start = act_reg && (uop_d_reg.save == tac_pkg::SV_DIV);

    tac_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_next),
        .den     (det_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                tx_reg[i] <= '0;
                ty_reg[i] <= '0;
            end
        end else begin
            act_reg <= cmd.issue;
            if (cmd.store && (in_pair_index != 2'd3)) begin
                sx_reg[in_pair_index] <= in_screen_x;
                sy_reg[in_pair_index] <= in_screen_y;
                tx_reg[in_pair_index] <= in_touch_x;
                ty_reg[in_pair_index] <= in_touch_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            ptx_reg <= in_touch_x;
            pty_reg <= in_touch_y;
        end
        if (cmd.issue) begin
            prod_reg  <= opa * opb;
            uop_d_reg <= cmd.uop;
        end
        if (act_reg) begin
            acc_reg <= acc_next;
            case (uop_d_reg.save)
                tac_pkg::SV_DET:  det_reg  <= acc_next[DEN_W-1:0];
                tac_pkg::SV_P:    p_reg    <= acc_next[PQR_W-1:0];
                tac_pkg::SV_Q:    q_reg    <= acc_next[PQR_W-1:0];
                tac_pkg::SV_R:    r_reg    <= acc_next[PQR_W-1:0];
                tac_pkg::SV_DIV:  dest_reg <= uop_d_reg.cidx + (cmd.k ? 3'd3 : 3'd0);
                tac_pkg::SV_OUTX: resx_reg <= shift_sat(acc_next);
                tac_pkg::SV_OUTY: resy_reg <= shift_sat(acc_next);
                default: ;
            endcase
        end
        if (div_done && (dest_reg < 3'd6)) begin
            coef_reg[dest_reg] <= div_quo;
        end
        if (cmd.out_load) begin
            case (cmd.out_sel)
                tac_pkg::OUT_PASS: begin
                    outx_reg <= ptx_reg;
                    outy_reg <= pty_reg;
                end
                tac_pkg::OUT_XFORM: begin
                    outx_reg <= resx_reg;
                    outy_reg <= resy_reg;
                end
                default: begin
                    outx_reg <= '0;
                    outy_reg <= '0;
                end
            endcase
        end
    end

    assign stat.det_zero = (det_reg == '0);
    assign stat.div_done = div_done;
    assign out_x = outx_reg;
    assign out_y = outy_reg;

endmodule

// File: design/tac_ctrl.sv
// Controller: command decode, micro-program sequencing, coefficient valid flag
// and result handshake. Depends on tac_pkg.
module tac_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tac_pkg::cmd_t      in_cmd,
    input  logic               in_pressed,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_coeff_valid,
    output logic               m_singular,
    output tac_pkg::dp_cmd_t   dp_cmd,
    input  tac_pkg::dp_stat_t  dp_stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_DRAIN = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [tac_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic                         k_reg, k_next;
    logic                         valid_reg, valid_next;
    logic                         sing_reg, sing_next;
    tac_pkg::out_sel_t            out_sel_reg, out_sel_next;
    logic                         mvalid_reg, mvalid_next;
    logic                         mcv_reg, mcv_next;
    logic                         msing_reg, msing_next;

    tac_pkg::uop_t                uop;
    logic                         accept;
    logic                         out_load;

    assign uop      = tac_pkg::tac_uop(pc_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!mvalid_reg || m_tready);

    assign dp_cmd.issue    = (state_reg == S_ISSUE);
    assign dp_cmd.uop      = uop;
    assign dp_cmd.k        = k_reg;
    assign dp_cmd.store    = accept && (in_cmd == tac_pkg::CMD_STORE);
    assign dp_cmd.ld_in    = accept;
    assign dp_cmd.out_load = out_load;
    assign dp_cmd.out_sel  = out_sel_reg;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        k_next       = k_reg;
        valid_next   = valid_reg;
        sing_next    = sing_reg;
        out_sel_next = out_sel_reg;
        mvalid_next  = mvalid_reg;
        mcv_next     = mcv_reg;
        msing_next   = msing_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sing_next = 1'b0;
                    case (in_cmd)
                        tac_pkg::CMD_SOLVE: begin
                            pc_next    = tac_pkg::PC_SOLVE;
                            k_next     = 1'b0;
                            state_next = S_ISSUE;
                        end
                        tac_pkg::CMD_XFORM: begin
                            if (in_pressed && valid_reg) begin
                                pc_next    = tac_pkg::PC_XFORM;
                                state_next = S_ISSUE;
                            end else begin
                                out_sel_next = tac_pkg::OUT_PASS;
                                state_next   = S_DONE;
                            end
                        end
                        default: begin
                            out_sel_next = tac_pkg::OUT_ZERO;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                if (uop.stop) begin
                    state_next = S_DRAIN;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                case (uop.save)
                    tac_pkg::SV_DET: state_next = S_CHECK;
                    tac_pkg::SV_DIV: state_next = S_DIV;
                    default: begin
                        out_sel_next = tac_pkg::OUT_XFORM;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                if (dp_stat.det_zero) begin
                    valid_next   = 1'b0;
                    sing_next    = 1'b1;
                    out_sel_next = tac_pkg::OUT_ZERO;
                    state_next   = S_DONE;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_DIV: begin
                if (dp_stat.div_done) begin
                    if (uop.cidx == tac_pkg::CIDX_N2) begin
                        if (k_reg) begin
                            valid_next   = 1'b1;
                            k_next       = 1'b0;
                            out_sel_next = tac_pkg::OUT_ZERO;
                            state_next   = S_DONE;
                        end else begin
                            k_next     = 1'b1;
                            pc_next    = tac_pkg::PC_LOOP;
                            state_next = S_ISSUE;
                        end
                    end else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    mcv_next    = valid_reg;
                    msing_next  = sing_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            k_reg       <= 1'b0;
            valid_reg   <= 1'b0;
            sing_reg    <= 1'b0;
            out_sel_reg <= tac_pkg::OUT_ZERO;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            k_reg       <= k_next;
            valid_reg   <= valid_next;
            sing_reg    <= sing_next;
            out_sel_reg <= out_sel_next;
            mvalid_reg  <= mvalid_next;
        end
        mcv_reg   <= mcv_next;
        msing_reg <= msing_next;
    end

    assign m_tvalid      = mvalid_reg;
    assign m_coeff_valid = mcv_reg;
    assign m_singular    = msing_reg;

endmodule

// File: design/touch_affine_calibration_core.sv
// Top level of the three-point affine touch calibration core.
// Instantiates tac_ctrl and tac_datapath; depends on tac_pkg.
//
// One transaction in, one transaction out, one item at a time. Store, unused
// command and pass-through points go from accept through the S_DONE state to
// the output register. A transform runs six multiply-accumulates through one
// shared 34x17 multiplier. In a solve the determinant and numerators go through
// the same multiplier, and each of the six coefficients passes through a
// restoring divider that yields one quotient bit per cycle. A finished result
// waits in the output register; the next item is taken once it has been handed
// over to that register.
module touch_affine_calibration_core #(
    parameter int FRAC_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // screen_x, screen_y, touch_x, touch_y
    input  logic [4:0]  s_tuser,   // command[1:0], pair_index[3:2], pressed[4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_x, out_y
    output logic [1:0]  m_tuser    // coeff_valid[0], singular[1]
);

    tac_pkg::dp_cmd_t  dp_cmd;
    tac_pkg::dp_stat_t dp_stat;
    logic              coeff_valid, singular;
    logic signed [tac_pkg::XY_W-1:0] out_x, out_y;

    tac_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_cmd        (tac_pkg::cmd_t'(s_tuser[1:0])),
        .in_pressed    (s_tuser[4]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_coeff_valid (coeff_valid),
        .m_singular    (singular),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat)
    );

    tac_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .in_pair_index (s_tuser[3:2]),
        .in_screen_x   (s_tdata[15:0]),
        .in_screen_y   (s_tdata[31:16]),
        .in_touch_x    (s_tdata[47:32]),
        .in_touch_y    (s_tdata[63:48]),
        .out_x         (out_x),
        .out_y         (out_y)
    );

    assign m_tdata = {out_y, out_x};
    assign m_tuser = {singular, coeff_valid};

endmodule

// File: design/tac_checker.sv
// Port-level checker for touch_affine_calibration_core, attached with bind.
// Sees only the top-level ports.
module tac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [4:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_singular_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == 32'd0))
        else $error("singular result with valid flag or nonzero point");

    // only when the output register is free, so the store result is the next one shown
    a_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] == tac_pkg::CMD_STORE)
            && (!m_tvalid || m_tready)
            |=> ##1 m_tvalid && (m_tdata == 32'd0) && !m_tuser[1])
        else $error("store command gave nonzero result");

endmodule

bind touch_affine_calibration_core tac_checker u_tac_checker (.*);

// File: sim/tb_touch_affine_calibration_core.sv
// Testbench for touch_affine_calibration_core: stores calibration pairs, solves and maps
// points against a behavioral model of the Q8 affine calibration. Depends on tac_pkg.
module tb_touch_affine_calibration_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = tac_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               valid;
        logic               sing;
    } touch_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    touch_affine_calibration_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // model state
    logic signed [15:0] scr_x [3];
    logic signed [15:0] scr_y [3];
    logic signed [15:0] tch_x [3];
    logic signed [15:0] tch_y [3];
    logic signed [31:0] coef [6];
    bit                 cal_ok;

    touch_result_t pending_results[$];
    int errors;
    int items_sent;
    int cmd_count [4];
    int singular_seen;
    int mapped_seen;
    int burst_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $realtime);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [31:0] q_div(longint num, longint den);
        bit neg;
        longint unsigned n, d, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n << FB) / d;
        if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    function automatic logic signed [15:0] floor_sat(longint v);
        longint r;
        r = v >>> FB;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Cramer's rule over the three stored pairs
    function automatic bit solve_cal();
        longint t0x, t0y, t1x, t1y, t2x, t2y, det, s0, s1, s2, n0, n1, n2;
        t0x = tch_x[0]; t0y = tch_y[0];
        t1x = tch_x[1]; t1y = tch_y[1];
        t2x = tch_x[2]; t2y = tch_y[2];
        det = t0x * (t2y - t1y) - t1x * t2y + t1y * t2x + t0y * (t1x - t2x);
        if (det == 0) begin
            cal_ok = 1'b0;
            return 1'b0;
        end
        for (int k = 0; k < 2; k++) begin
            s0 = k ? scr_y[0] : scr_x[0];
            s1 = k ? scr_y[1] : scr_x[1];
            s2 = k ? scr_y[2] : scr_x[2];
            n0 = s0 * (t2y - t1y) - s1 * t2y + s2 * t1y + (s1 - s2) * t0y;
            n1 = -(s0 * (t2x - t1x) - s1 * t2x + s2 * t1x + (s1 - s2) * t0x);
            n2 = s0 * (t1y * t2x - t1x * t2y) + t0x * (s1 * t2y - s2 * t1y)
               + t0y * (s2 * t1x - s1 * t2x);
            coef[3*k]   = q_div(n0, det);
            coef[3*k+1] = q_div(n1, det);
            coef[3*k+2] = q_div(n2, det);
        end
        cal_ok = 1'b1;
        return 1'b1;
    endfunction

    task automatic predict_touch(tac_pkg::cmd_t cmd, logic [1:0] idx, logic signed [15:0] sx,
                                 logic signed [15:0] sy, logic signed [15:0] tx,
                                 logic signed [15:0] ty, logic pressed);
        touch_result_t r;
        longint vx, vy;
        r = '{16'sd0, 16'sd0, 1'b0, 1'b0};
        case (cmd)
            tac_pkg::CMD_STORE: begin
                if (idx < 3) begin
                    scr_x[idx] = sx; scr_y[idx] = sy;
                    tch_x[idx] = tx; tch_y[idx] = ty;
                end
            end
            tac_pkg::CMD_SOLVE: r.sing = !solve_cal();
            tac_pkg::CMD_XFORM: begin
                if (pressed && cal_ok) begin
                    vx = longint'(coef[0]) * tx + longint'(coef[1]) * ty + coef[2];
                    vy = longint'(coef[3]) * tx + longint'(coef[4]) * ty + coef[5];
                    r.x = floor_sat(vx);
                    r.y = floor_sat(vy);
                    mapped_seen++;
                end else begin
                    r.x = tx; r.y = ty;
                end
            end
            default: ;
        endcase
        r.valid = cal_ok;
        if (r.sing) singular_seen++;
        cmd_count[cmd]++;
        pending_results.push_back(r);
    endtask

    // one transaction on the input side; bursts with random gaps between them
    task automatic send_item(tac_pkg::cmd_t cmd, logic [1:0] idx, logic signed [15:0] sx,
                             logic signed [15:0] sy, logic signed [15:0] tx,
                             logic signed [15:0] ty, logic pressed);
        s_tdata  <= {ty, tx, sy, sx};
        s_tuser  <= {pressed, idx, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_touch(cmd, idx, sx, sy, tx, ty, pressed);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    // receiver: stall pattern switches between always-ready, light and heavy stalls
    int stall_mode;
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        touch_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: data %h user %b",
                         $realtime, m_tdata, m_tuser);
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[15:0] !== e.x) begin
                    errors++;
                    $display("%0t: out_x exp %0d got %0d", $realtime, e.x,
                             $signed(m_tdata[15:0]));
                end
                if (m_tdata[31:16] !== e.y) begin
                    errors++;
                    $display("%0t: out_y exp %0d got %0d", $realtime, e.y,
                             $signed(m_tdata[31:16]));
                end
                if (m_tuser[0] !== e.valid) begin
                    errors++;
                    $display("%0t: coeff_valid exp %b got %b", $realtime, e.valid, m_tuser[0]);
                end
                if (m_tuser[1] !== e.sing) begin
                    errors++;
                    $display("%0t: singular exp %b got %b", $realtime, e.sing, m_tuser[1]);
                end
            end
        end
    end

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom());
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    task automatic test_edges();
        // zero points after reset: singular, then maps pass through
        send_item(tac_pkg::CMD_SOLVE, 2'd0, 0, 0, 0, 0, 1'b0);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, -16'sd32768, 16'sd32767, 1'b1);
        send_item(tac_pkg::CMD_NOP, 2'd3, -1, -1, -1, -1, 1'b1);
        send_item(tac_pkg::CMD_STORE, 2'd3, 16'sd32767, -16'sd32768, 16'sd5, 16'sd5, 1'b1);
        send_item(tac_pkg::CMD_STORE, 2'd0, -16'sd32768, -16'sd32768, -16'sd32768,
                  -16'sd32768, 1'b0);
        send_item(tac_pkg::CMD_STORE, 2'd1, 16'sd32767, -16'sd32768, 16'sd32767,
                  -16'sd32768, 1'b1);
        send_item(tac_pkg::CMD_STORE, 2'd2, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd32767, 1'b0);
        send_item(tac_pkg::CMD_SOLVE, 2'd3, -1, -1, -1, -1, 1'b1);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, 16'sd32767, 16'sd32767, 1'b1);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, -16'sd32768, -16'sd32768, 1'b1);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, 16'sd1234, -16'sd321, 1'b0);
        // tiny determinant with large coordinates drives the coefficients to saturation
        send_item(tac_pkg::CMD_STORE, 2'd0, 16'sd32767, -16'sd32768, 16'sd32767,
                  16'sd32766, 1'b0);
        send_item(tac_pkg::CMD_STORE, 2'd1, -16'sd32768, 16'sd32767, 16'sd32766,
                  16'sd32765, 1'b0);
        send_item(tac_pkg::CMD_STORE, 2'd2, 16'sd32767, 16'sd32767, 16'sd0, 16'sd1, 1'b0);
        send_item(tac_pkg::CMD_SOLVE, 2'd0, 0, 0, 0, 0, 1'b0);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, 16'sd100, -16'sd100, 1'b1);
        send_item(tac_pkg::CMD_NOP, 2'd0, 0, 0, 0, 0, 1'b0);
        // duplicate point makes a valid set singular again
        send_item(tac_pkg::CMD_STORE, 2'd2, 16'sd7, 16'sd9, 16'sd32767, 16'sd32766, 1'b0);
        send_item(tac_pkg::CMD_SOLVE, 2'd0, 0, 0, 0, 0, 1'b0);
        send_item(tac_pkg::CMD_XFORM, 2'd0, 0, 0, 16'sd77, 16'sd88, 1'b1);
    endtask

    // calibration sessions: three pairs, solve, then a run of points; some noise mixed in
    task automatic test_calibrate_and_map(int target);
        int scale, off_x, off_y, n;
        logic signed [15:0] tx, ty;
        while (items_sent < target) begin
            scale = $urandom_range(1, 8);
            off_x = $urandom_range(0, 2000) - 1000;
            off_y = $urandom_range(0, 2000) - 1000;
            for (int p = 0; p < 3; p++) begin
                case ($urandom_range(0, 5))
                    0: begin tx = rnd16(); ty = rnd16(); end
                    1: begin
                        tx = 16'(tch_x[0] + $urandom_range(0, 2) - 1);
                        ty = tch_y[0];
                    end
                    default: begin
                        tx = 16'($urandom_range(0, 8000) - 4000);
                        ty = 16'($urandom_range(0, 8000) - 4000);
                    end
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_item(tac_pkg::CMD_STORE, 2'(p), rnd16(), rnd16(), tx, ty,
                              1'($urandom()));
                else
                    send_item(tac_pkg::CMD_STORE, 2'(p), clip16(tx / scale + off_x),
                              clip16(ty / scale + off_y), tx, ty, 1'($urandom()));
                if ($urandom_range(0, 15) == 0)
                    send_item(tac_pkg::CMD_STORE, 2'd3, rnd16(), rnd16(), rnd16(), rnd16(),
                              1'($urandom()));
            end
            send_item(tac_pkg::CMD_SOLVE, 2'($urandom()), rnd16(), rnd16(), rnd16(), rnd16(),
                      1'($urandom()));
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    tx = rnd16(); ty = rnd16();
                end else begin
                    tx = 16'($urandom_range(0, 8000) - 4000);
                    ty = 16'($urandom_range(0, 8000) - 4000);
                end
                if ($urandom_range(0, 7) == 0)
                    send_item(tac_pkg::cmd_t'($urandom_range(0, 3)), 2'($urandom()),
                              rnd16(), rnd16(), tx, ty, 1'($urandom()));
                else
                    send_item(tac_pkg::CMD_XFORM, 2'($urandom()), rnd16(), rnd16(), tx, ty,
                              $urandom_range(0, 5) != 0);
            end
        end
    endtask

    initial begin
        int waited;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        errors = 0;
        items_sent = 0;
        singular_seen = 0;
        mapped_seen = 0;
        burst_left = 5;
        cmd_count = '{0, 0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            scr_x[i] = 0; scr_y[i] = 0; tch_x[i] = 0; tch_y[i] = 0;
        end
        for (int i = 0; i < 6; i++) coef[i] = 0;
        cal_ok = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edges();
        test_calibrate_and_map(1050);
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (30) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $realtime, pending_results.size());
        end

        $display("%0d transactions: %0d store, %0d solve (%0d singular), %0d map (%0d mapped)",
                 items_sent, cmd_count[tac_pkg::CMD_STORE], cmd_count[tac_pkg::CMD_SOLVE],
                 singular_seen, cmd_count[tac_pkg::CMD_XFORM], mapped_seen);
        $display("%0d unused commands, %0d errors", cmd_count[tac_pkg::CMD_NOP], errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
